// ===== rtl/core/gda_pkg.sv =====
// ============================================================================
// Gregorian date adder package
// Shared types, codes, calendar helpers and the sequencer's control program.
// ============================================================================
package gda_pkg;

  localparam int unsigned DayW   = 6;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned AmtW   = 16;
  // Working width: holds a start year plus the largest amount.
  localparam int unsigned WorkW  = 17;
  localparam int unsigned PcW    = 4;

  localparam logic [YearW-1:0] MinYearReset = 12'd1900;
  localparam logic [YearW-1:0] MaxYearReset = 12'd2100;
  localparam logic [YearW-1:0] YearSat      = 12'd4095;
  localparam logic [WorkW-1:0] Era          = 17'd400;

  // Reciprocal of 12 scaled by 2^19, exact for every month offset that occurs.
  localparam logic [AmtW-1:0]  Recip12      = 16'd43691;
  localparam int unsigned      Recip12Shift = 19;
  localparam int unsigned      QuotW        = 13;

  typedef enum logic [1:0] {
    OPR_DAYS     = 2'd0,
    OPR_MONTHS   = 2'd1,
    OPR_YEARS    = 2'd2,
    OPR_VALIDATE = 2'd3
  } opr_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DAY   = 2'd1,
    ST_BAD_MONTH = 2'd2,
    ST_BAD_YEAR  = 2'd3
  } status_e;

  typedef enum logic {
    REG_MIN_YEAR = 1'b0,
    REG_MAX_YEAR = 1'b1
  } reg_e;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    U_NOP,
    U_RED,
    U_CHK0,
    U_ADD_DAYS,
    U_DSTEP,
    U_MUL,
    U_MDIV,
    U_CLAMP,
    U_ADD_YRS,
    U_CHKEND,
    U_EMIT
  } uop_e;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_R_GE_ERA,
    C_BAD,
    C_D_GT_MLEN,
    C_OUT_BUSY,
    C_OP_DAYS,
    C_OP_MONTHS,
    C_OP_YEARS
  } cond_e;

  typedef struct packed {
    uop_e           uop;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           last;
  } ctrl_t;

  typedef struct packed {
    logic r_ge_era;
    logic bad;
    logic d_gt_mlen;
    logic out_busy;
    logic op_days;
    logic op_months;
    logic op_years;
  } flags_t;

  // Program step addresses.
  localparam logic [PcW-1:0] PcStart  = 4'd0;
  localparam logic [PcW-1:0] PcDays   = 4'd6;
  localparam logic [PcW-1:0] PcDstep  = 4'd7;
  localparam logic [PcW-1:0] PcMonths = 4'd9;
  localparam logic [PcW-1:0] PcRed    = 4'd11;
  localparam logic [PcW-1:0] PcYears  = 4'd13;
  localparam logic [PcW-1:0] PcChkEnd = 4'd14;
  localparam logic [PcW-1:0] PcEmit   = 4'd15;

  // Control store: one word per step.
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{uop: U_NOP, cond: C_ALWAYS, target: PcChkEnd, last: 1'b0};
    case (pc)
      4'd0:  w = '{uop: U_RED,      cond: C_R_GE_ERA,  target: PcStart,  last: 1'b0};
      4'd1:  w = '{uop: U_CHK0,     cond: C_BAD,       target: PcEmit,   last: 1'b0};
      4'd2:  w = '{uop: U_NOP,      cond: C_OP_DAYS,   target: PcDays,   last: 1'b0};
      4'd3:  w = '{uop: U_NOP,      cond: C_OP_MONTHS, target: PcMonths, last: 1'b0};
      4'd4:  w = '{uop: U_NOP,      cond: C_OP_YEARS,  target: PcYears,  last: 1'b0};
      4'd5:  w = '{uop: U_NOP,      cond: C_ALWAYS,    target: PcChkEnd, last: 1'b0};
      4'd6:  w = '{uop: U_ADD_DAYS, cond: C_NEVER,     target: PcStart,  last: 1'b0};
      4'd7:  w = '{uop: U_DSTEP,    cond: C_D_GT_MLEN, target: PcDstep,  last: 1'b0};
      4'd8:  w = '{uop: U_NOP,      cond: C_ALWAYS,    target: PcChkEnd, last: 1'b0};
      4'd9:  w = '{uop: U_MUL,      cond: C_NEVER,     target: PcStart,  last: 1'b0};
      4'd10: w = '{uop: U_MDIV,     cond: C_NEVER,     target: PcStart,  last: 1'b0};
      4'd11: w = '{uop: U_RED,      cond: C_R_GE_ERA,  target: PcRed,    last: 1'b0};
      4'd12: w = '{uop: U_CLAMP,    cond: C_ALWAYS,    target: PcChkEnd, last: 1'b0};
      4'd13: w = '{uop: U_ADD_YRS,  cond: C_ALWAYS,    target: PcRed,    last: 1'b0};
      4'd14: w = '{uop: U_CHKEND,   cond: C_NEVER,     target: PcStart,  last: 1'b0};
      4'd15: w = '{uop: U_EMIT,     cond: C_OUT_BUSY,  target: PcEmit,   last: 1'b1};
      default: w = '{uop: U_NOP,    cond: C_ALWAYS,    target: PcChkEnd, last: 1'b0};
    endcase
    return w;
  endfunction

  // Leap year from the year reduced modulo 400.
  function automatic logic is_leap(input logic [WorkW-1:0] r);
    return (r[1:0] == 2'b00) && (r != 17'd100) && (r != 17'd200) && (r != 17'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Year window first, then month, then day.
  function automatic status_e check_date(input logic [WorkW-1:0] d,
                                         input logic [MonW-1:0]  m,
                                         input logic [WorkW-1:0] y,
                                         input logic [4:0]       mlen,
                                         input logic [YearW-1:0] min_y,
                                         input logic [YearW-1:0] max_y);
    status_e st;
    if ((y < {{(WorkW-YearW){1'b0}}, min_y}) || (y > {{(WorkW-YearW){1'b0}}, max_y})) begin
      st = ST_BAD_YEAR;
    end else if ((m < 4'd1) || (m > 4'd12)) begin
      st = ST_BAD_MONTH;
    end else if ((d < 17'd1) || (d > {{(WorkW-5){1'b0}}, mlen})) begin
      st = ST_BAD_DAY;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

// ===== rtl/core/gda_sequencer.sv =====
// ============================================================================
// Gregorian date adder sequencer
// Step counter over the control store, with conditional jumps on datapath flags.
// ============================================================================
module gda_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  gda_pkg::flags_t   flags_i,
  output gda_pkg::ctrl_t    ctrl_o,
  output logic              busy_o
);

  logic [gda_pkg::PcW-1:0] pc_q, pc_d;
  logic                    busy_q, busy_d;
  logic                    jump;

  assign ctrl_o = gda_pkg::ucode(pc_q);
  assign busy_o = busy_q;

  // Evaluate the jump condition of the current step.
  always_comb begin
    case (ctrl_o.cond)
      gda_pkg::C_NEVER:     jump = 1'b0;
      gda_pkg::C_ALWAYS:    jump = 1'b1;
      gda_pkg::C_R_GE_ERA:  jump = flags_i.r_ge_era;
      gda_pkg::C_BAD:       jump = flags_i.bad;
      gda_pkg::C_D_GT_MLEN: jump = flags_i.d_gt_mlen;
      gda_pkg::C_OUT_BUSY:  jump = flags_i.out_busy;
      gda_pkg::C_OP_DAYS:   jump = flags_i.op_days;
      gda_pkg::C_OP_MONTHS: jump = flags_i.op_months;
      gda_pkg::C_OP_YEARS:  jump = flags_i.op_years;
      default:              jump = 1'b0;
    endcase
  end

  // Next step and busy flag.
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = gda_pkg::PcStart;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (jump) begin
        pc_d = ctrl_o.target;
      end else if (ctrl_o.last) begin
        pc_d   = gda_pkg::PcStart;
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= gda_pkg::PcStart;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== rtl/core/gregorian_date_adder.sv =====
// ============================================================================
// Gregorian date adder
// Adds days, months or years to a date, or validates it, with year-window checks.
// ============================================================================
// One transaction is taken at a time; in_stall_o stays high while it is in
// work. The start year is first reduced modulo 400 for the leap rule, by
// repeated subtraction, and the start date is checked; an invalid start date
// goes straight to the output step. Adding days then steps through each month
// boundary crossed; adding months or years reduces the result year modulo 400
// again and clamps the day to the month length. Every valid transaction ends
// with a check of the result date.
// The result sits in an output register, and a new transaction may be taken
// while it waits, but the next result is held until that register is free.
module gregorian_date_adder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [11:0] start_year_i,
  input  logic [15:0] amount_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [11:0] result_year_o,
  output logic [1:0]  status_o
);

  localparam int unsigned WorkW = gda_pkg::WorkW;
  localparam int unsigned YearW = gda_pkg::YearW;
  localparam int unsigned MonW  = gda_pkg::MonW;

  logic [YearW-1:0]      min_year_q, max_year_q;
  gda_pkg::opr_e         opr_q, opr_d;
  logic [WorkW-1:0]      d_q, d_d;
  logic [MonW-1:0]       m_q, m_d;
  logic [WorkW-1:0]      y_q, y_d;
  logic [WorkW-1:0]      r_q, r_d;
  logic [WorkW-1:0]      t_q, t_d;
  logic [gda_pkg::QuotW-1:0] q_q, q_d;
  gda_pkg::status_e      st_q, st_d;
  logic [15:0]           amt_q, amt_d;

  logic                  out_valid_q, out_valid_d;
  logic [4:0]            out_day_q, out_day_d;
  logic [MonW-1:0]       out_mon_q, out_mon_d;
  logic [YearW-1:0]      out_year_q, out_year_d;
  gda_pkg::status_e      out_st_q, out_st_d;

  gda_pkg::ctrl_t        ctrl;
  gda_pkg::flags_t       flags;
  logic                  busy;
  logic                  start;
  logic                  out_busy;
  logic                  emit_fire;
  logic [4:0]            mlen;
  gda_pkg::status_e      chk;
  logic [WorkW-1:0]      t_sum;
  logic [31:0]           prod;
  logic [WorkW-1:0]      rem12;
  logic [WorkW-1:0]      y_sum;

  assign start      = in_valid_i && !in_stall_o;
  assign in_stall_o = busy;
  assign out_busy   = out_valid_q && out_stall_i;
  assign emit_fire  = busy && (ctrl.uop == gda_pkg::U_EMIT) && !out_busy;

  // Calendar view of the working date.
  assign mlen = gda_pkg::month_len(m_q, gda_pkg::is_leap(r_q));
  assign chk  = gda_pkg::check_date(d_q, m_q, y_q, mlen, min_year_q, max_year_q);

  // Month arithmetic: offset, quotient by reciprocal, remainder from quotient.
  assign t_sum = {{(WorkW-MonW){1'b0}}, m_q} - 17'd1 + {1'b0, amt_q};
  assign prod  = t_sum[15:0] * gda_pkg::Recip12 + (t_sum[16] ? {gda_pkg::Recip12, 16'd0} : 32'd0);
  assign rem12 = t_q - ({{(WorkW-gda_pkg::QuotW-3){1'b0}}, q_q, 3'b000}
                      + {{(WorkW-gda_pkg::QuotW-2){1'b0}}, q_q, 2'b00});
  assign y_sum = (ctrl.uop == gda_pkg::U_MDIV)
               ? y_q + {{(WorkW-gda_pkg::QuotW){1'b0}}, q_q}
               : y_q + {1'b0, amt_q};

  // Flags for the sequencer.
  always_comb begin
    flags.r_ge_era  = r_q >= gda_pkg::Era;
    flags.bad       = chk != gda_pkg::ST_OK;
    flags.d_gt_mlen = d_q > {{(WorkW-5){1'b0}}, mlen};
    flags.out_busy  = out_busy;
    flags.op_days   = opr_q == gda_pkg::OPR_DAYS;
    flags.op_months = opr_q == gda_pkg::OPR_MONTHS;
    flags.op_years  = opr_q == gda_pkg::OPR_YEARS;
  end

  gda_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= gda_pkg::MinYearReset;
      max_year_q <= gda_pkg::MaxYearReset;
    end else if (cfg_we_i) begin
      case (gda_pkg::reg_e'(cfg_idx_i))
        gda_pkg::REG_MIN_YEAR: min_year_q <= cfg_data_i;
        gda_pkg::REG_MAX_YEAR: max_year_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Datapath: one micro-operation per step.
  always_comb begin
    opr_d = opr_q;
    d_d   = d_q;
    m_d   = m_q;
    y_d   = y_q;
    r_d   = r_q;
    t_d   = t_q;
    q_d   = q_q;
    st_d  = st_q;
    amt_d = amt_q;
    if (start) begin
      opr_d = gda_pkg::opr_e'(operation_i);
      d_d   = {{(WorkW-6){1'b0}}, start_day_i};
      m_d   = start_month_i;
      y_d   = {{(WorkW-YearW){1'b0}}, start_year_i};
      r_d   = {{(WorkW-YearW){1'b0}}, start_year_i};
      amt_d = amount_i;
    end else if (busy) begin
      case (ctrl.uop)
        gda_pkg::U_RED: begin
          if (flags.r_ge_era) begin
            r_d = r_q - gda_pkg::Era;
          end
        end
        gda_pkg::U_CHK0: begin
          st_d = chk;
          if (flags.bad) begin
            d_d = '0;
            m_d = '0;
            y_d = '0;
          end
        end
        gda_pkg::U_ADD_DAYS: begin
          d_d = d_q + {1'b0, amt_q};
        end
        gda_pkg::U_DSTEP: begin
          if (flags.d_gt_mlen) begin
            d_d = d_q - {{(WorkW-5){1'b0}}, mlen};
            if (m_q == 4'd12) begin
              m_d = 4'd1;
              y_d = y_q + 17'd1;
              r_d = (r_q == gda_pkg::Era - 17'd1) ? '0 : r_q + 17'd1;
            end else begin
              m_d = m_q + 4'd1;
            end
          end
        end
        gda_pkg::U_MUL: begin
          t_d = t_sum;
          q_d = prod[31:gda_pkg::Recip12Shift];
        end
        gda_pkg::U_MDIV: begin
          y_d = y_sum;
          r_d = y_sum;
          m_d = rem12[MonW-1:0] + 4'd1;
        end
        gda_pkg::U_ADD_YRS: begin
          y_d = y_sum;
          r_d = y_sum;
        end
        gda_pkg::U_CLAMP: begin
          if (flags.d_gt_mlen) begin
            d_d = {{(WorkW-5){1'b0}}, mlen};
          end
        end
        gda_pkg::U_CHKEND: begin
          st_d = chk;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    opr_q <= opr_d;
    d_q   <= d_d;
    m_q   <= m_d;
    y_q   <= y_d;
    r_q   <= r_d;
    t_q   <= t_d;
    q_q   <= q_d;
    st_q  <= st_d;
    amt_q <= amt_d;
  end

  // Output register: loaded by the final step, cleared when its transaction is taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_day_d   = out_day_q;
    out_mon_d   = out_mon_q;
    out_year_d  = out_year_q;
    out_st_d    = out_st_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
      out_day_d   = d_q[4:0];
      out_mon_d   = m_q;
      out_year_d  = (y_q > {{(WorkW-YearW){1'b0}}, gda_pkg::YearSat})
                  ? gda_pkg::YearSat : y_q[YearW-1:0];
      out_st_d    = st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_day_q  <= out_day_d;
    out_mon_q  <= out_mon_d;
    out_year_q <= out_year_d;
    out_st_q   <= out_st_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_day_o   = out_day_q;
  assign result_month_o = out_mon_q;
  assign result_year_o  = out_year_q;
  assign status_o       = out_st_q;

  // A taken transaction starts work on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("sequencer not busy after an input transaction");

  // The final step frees the block and presents a result.
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (!busy && out_valid_o))
    else $error("final step did not free the block or load the output");

  // The leap rule needs a fully reduced year wherever the month length is used.
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && (ctrl.uop == gda_pkg::U_CHK0 || ctrl.uop == gda_pkg::U_DSTEP
              || ctrl.uop == gda_pkg::U_CLAMP || ctrl.uop == gda_pkg::U_CHKEND))
    |-> (r_q < gda_pkg::Era))
    else $error("year residue not reduced when month length is used");

  // A good result always has a real month and day.
  a_good_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == gda_pkg::ST_OK)
    |-> (result_month_o >= 4'd1 && result_month_o <= 4'd12 && result_day_o != 5'd0))
    else $error("result with good status has an impossible month or day");

endmodule

// ===== sim/date_result_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Date result checker
// Watches the configuration port and both channels of the date adder. For
// every transaction taken on the input it works out the resulting date and
// status. It compares each result transaction, field by field, against the
// oldest outstanding date.
// ============================================================================
module date_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [11:0] start_year_i,
  input  logic [15:0] amount_i,
  // Output channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [4:0]  result_day_i,
  input  logic [3:0]  result_month_i,
  input  logic [11:0] result_year_i,
  input  logic [1:0]  status_i,
  // Totals for the testbench top
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [11:0]      year;
    gda_pkg::status_e status;
  } date_res_t;

  // The checker's own copy of the year window.
  logic [11:0] year_lo = gda_pkg::MinYearReset;
  logic [11:0] year_hi = gda_pkg::MaxYearReset;

  date_res_t   expected_dates[$];
  date_res_t   oldest;
  int unsigned mismatches  = 0;
  int unsigned outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = outstanding;

  // A year is a leap year when divisible by 4 but not by 100, or by 400.
  function automatic logic leap_year(input logic [16:0] y);
    return (((y % 17'd4) == 17'd0) && ((y % 17'd100) != 17'd0)) || ((y % 17'd400) == 17'd0);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [16:0] y);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap_year(y) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // The year window comes first, then the month, then the day.
  function automatic gda_pkg::status_e date_check(input logic [16:0] d, input logic [3:0] m,
                                                  input logic [16:0] y, input logic [11:0] lo,
                                                  input logic [11:0] hi);
    gda_pkg::status_e st;
    if ((y < {5'd0, lo}) || (y > {5'd0, hi})) begin
      st = gda_pkg::ST_BAD_YEAR;
    end else if ((m < 4'd1) || (m > 4'd12)) begin
      st = gda_pkg::ST_BAD_MONTH;
    end else if ((d < 17'd1) || (d > {12'd0, month_days(m, y)})) begin
      st = gda_pkg::ST_BAD_DAY;
    end else begin
      st = gda_pkg::ST_OK;
    end
    return st;
  endfunction

  // Adds the amount per operation to a valid start date; checks the outcome.
  function automatic date_res_t advance_date(input gda_pkg::opr_e op, input logic [5:0] day,
                                             input logic [3:0] month, input logic [11:0] year,
                                             input logic [15:0] amount, input logic [11:0] lo,
                                             input logic [11:0] hi);
    logic [16:0]      d;
    logic [16:0]      y;
    logic [16:0]      t;
    logic [3:0]       m;
    gda_pkg::status_e st;
    date_res_t        res;
    d  = {11'd0, day};
    m  = month;
    y  = {5'd0, year};
    st = date_check(d, m, y, lo, hi);
    if (st != gda_pkg::ST_OK) begin
      res = '{day: '0, month: '0, year: '0, status: st};
      return res;
    end
    case (op)
      gda_pkg::OPR_DAYS: begin
        // Peel off whole months until the day fits.
        d = d + {1'b0, amount};
        while (d > {12'd0, month_days(m, y)}) begin
          d = d - {12'd0, month_days(m, y)};
          if (m == 4'd12) begin
            m = 4'd1;
            y = y + 17'd1;
          end else begin
            m = m + 4'd1;
          end
        end
      end
      gda_pkg::OPR_MONTHS: begin
        t = {13'd0, m - 4'd1} + {1'b0, amount};
        y = y + t / 17'd12;
        t = t % 17'd12;
        m = t[3:0] + 4'd1;
        if (d > {12'd0, month_days(m, y)}) begin
          d = {12'd0, month_days(m, y)};
        end
      end
      gda_pkg::OPR_YEARS: begin
        y = y + {1'b0, amount};
        if (d > {12'd0, month_days(m, y)}) begin
          d = {12'd0, month_days(m, y)};
        end
      end
      default: begin
      end
    endcase
    // The window check sees the full year; only the reported year saturates.
    res.status = date_check(d, m, y, lo, hi);
    res.day    = d[4:0];
    res.month  = m;
    res.year   = (y > {5'd0, gda_pkg::YearSat}) ? gda_pkg::YearSat : y[11:0];
    return res;
  endfunction

  task automatic compare_field(input string label, input logic [11:0] want,
                               input logic [11:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  // Results are retired before new transactions are added, so a result and an
  // input on the same edge are ordered correctly.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_lo <= gda_pkg::MinYearReset;
      year_hi <= gda_pkg::MaxYearReset;
      expected_dates.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          mismatches++;
          $display({"%0t: result with no transaction outstanding: expected none, ",
                    "actual %0d-%0d-%0d status %0d"},
                   $time, result_year_i, result_month_i, result_day_i, status_i);
        end else begin
          oldest = expected_dates.pop_front();
          outstanding--;
          compare_field("day", {7'd0, oldest.day}, {7'd0, result_day_i});
          compare_field("month", {8'd0, oldest.month}, {8'd0, result_month_i});
          compare_field("year", oldest.year, result_year_i);
          compare_field("status", {10'd0, oldest.status}, {10'd0, status_i});
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_dates.push_back(advance_date(gda_pkg::opr_e'(operation_i), start_day_i,
                                              start_month_i, start_year_i, amount_i,
                                              year_lo, year_hi));
        outstanding++;
      end
      if (cfg_we_i) begin
        case (gda_pkg::reg_e'(cfg_idx_i))
          gda_pkg::REG_MIN_YEAR: year_lo <= cfg_data_i;
          gda_pkg::REG_MAX_YEAR: year_hi <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Gregorian date adder testbench
// Drives directed and random dates through the adder under several year
// windows, with bursty input traffic and a receiver that stalls on a pattern
// of its own. The checker instance predicts and compares every result.
// ============================================================================
module testbench;

  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned HoldOffCycles = 600;
  localparam int unsigned QuietLimit    = 20000;
  localparam int unsigned DrainCycles   = 64;
  localparam int unsigned PhaseItems    = 45;

  typedef struct packed {
    gda_pkg::opr_e op;
    logic [5:0]    day;
    logic [3:0]    month;
    logic [11:0]   year;
    logic [15:0]   amount;
  } date_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [11:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [5:0]  start_day_i;
  logic [3:0]  start_month_i;
  logic [11:0] start_year_i;
  logic [15:0] amount_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  result_day_o;
  logic [3:0]  result_month_o;
  logic [11:0] result_year_o;
  logic [1:0]  status_o;

  // Year window as last written, used to shape the random dates.
  logic [11:0] win_lo;
  logic [11:0] win_hi;
  logic        squeeze_req;
  int unsigned mismatches;
  int unsigned outstanding;

  gregorian_date_adder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .status_o       (status_o)
  );

  date_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .start_day_i      (start_day_i),
    .start_month_i    (start_month_i),
    .start_year_i     (start_year_i),
    .amount_i         (amount_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_day_i     (result_day_o),
    .result_month_i   (result_month_o),
    .result_year_i    (result_year_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver changes its stall habit at random intervals. Once, when
  // asked, it holds off long enough for the adder to back up its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    logic        squeezed;
    out_stall_i = 1'b0;
    squeezed    = 1'b0;
    tick        = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 128);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        if (squeeze_req && !squeezed) begin
          squeezed = 1'b1;
          out_stall_i <= 1'b1;
          repeat (HoldOffCycles) @(negedge clk_i);
        end
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // Presents one transaction and waits until the adder takes it.
  task automatic offer(input gda_pkg::opr_e op, input logic [5:0] day,
                       input logic [3:0] month, input logic [11:0] year,
                       input logic [15:0] amount);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    start_day_i   <= day;
    start_month_i <= month;
    start_year_i  <= year;
    amount_i      <= amount;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Lets every outstanding result drain so the window can be changed safely.
  task automatic settle();
    idle(1);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [11:0] lo, input logic [11:0] hi);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= gda_pkg::REG_MIN_YEAR;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_idx_i  <= gda_pkg::REG_MAX_YEAR;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  // Mostly well-formed dates near the window, with some raw noise.
  function automatic date_item_t random_item();
    date_item_t it;
    int unsigned pick;
    if ($urandom_range(0, 99) < 15) begin
      it.op     = gda_pkg::opr_e'($urandom_range(0, 3));
      it.day    = 6'($urandom_range(0, 63));
      it.month  = 4'($urandom_range(0, 15));
      it.year   = 12'($urandom_range(0, 4095));
      it.amount = 16'($urandom_range(0, 65535));
      return it;
    end
    it.op    = gda_pkg::opr_e'($urandom_range(0, 3));
    it.month = 4'($urandom_range(1, 12));
    it.day   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(29, 31))
                                           : 6'($urandom_range(1, 28));
    if ((win_lo <= win_hi) && ($urandom_range(0, 9) != 0)) begin
      it.year = 12'($urandom_range(win_lo, win_hi));
    end else begin
      it.year = 12'($urandom_range(0, 4095));
    end
    // Full-range amounts are rare because long day additions are slow.
    pick = $urandom_range(0, 19);
    case (it.op)
      gda_pkg::OPR_DAYS: begin
        if (pick == 0) begin
          it.amount = 16'($urandom_range(0, 65535));
        end else if (pick < 4) begin
          it.amount = 16'($urandom_range(0, 3000));
        end else begin
          it.amount = 16'($urandom_range(0, 62));
        end
      end
      gda_pkg::OPR_MONTHS: begin
        it.amount = (pick == 0) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 40));
      end
      gda_pkg::OPR_YEARS: begin
        it.amount = (pick == 0) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 150));
      end
      default: it.amount = 16'($urandom_range(0, 65535));
    endcase
    return it;
  endfunction

  // Random transactions in bursts with random gaps between them.
  task automatic random_phase(input int unsigned count);
    date_item_t  it;
    int unsigned burst_left;
    burst_left = $urandom_range(1, 8);
    repeat (count) begin
      it = random_item();
      offer(it.op, it.day, it.month, it.year, it.amount);
      burst_left--;
      if (burst_left == 0) begin
        idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end
    end
  endtask

  initial begin : stimulus
    logic [11:0] lo;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = gda_pkg::REG_MIN_YEAR;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    operation_i   = gda_pkg::OPR_VALIDATE;
    start_day_i   = '0;
    start_month_i = '0;
    start_year_i  = '0;
    amount_i      = '0;
    squeeze_req   = 1'b0;
    win_lo        = gda_pkg::MinYearReset;
    win_hi        = gda_pkg::MaxYearReset;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Leap rules, invalid fields and clamping under the reset window.
    offer(gda_pkg::OPR_VALIDATE, 6'd29, 4'd2, 12'd2000, 16'd0);
    offer(gda_pkg::OPR_VALIDATE, 6'd29, 4'd2, 12'd1900, 16'd65535);
    offer(gda_pkg::OPR_VALIDATE, 6'd29, 4'd2, 12'd2024, 16'd0);
    offer(gda_pkg::OPR_VALIDATE, 6'd15, 4'd6, 12'd1899, 16'd0);
    offer(gda_pkg::OPR_VALIDATE, 6'd1, 4'd1, 12'd2101, 16'd0);
    offer(gda_pkg::OPR_DAYS, 6'd10, 4'd0, 12'd2000, 16'd5);
    offer(gda_pkg::OPR_MONTHS, 6'd10, 4'd13, 12'd2000, 16'd5);
    offer(gda_pkg::OPR_YEARS, 6'd10, 4'd15, 12'd2000, 16'd5);
    offer(gda_pkg::OPR_DAYS, 6'd0, 4'd5, 12'd2000, 16'd1);
    offer(gda_pkg::OPR_DAYS, 6'd63, 4'd5, 12'd2000, 16'd1);
    offer(gda_pkg::OPR_DAYS, 6'd31, 4'd4, 12'd2000, 16'd1);
    offer(gda_pkg::OPR_DAYS, 6'd17, 4'd8, 12'd2010, 16'd0);
    offer(gda_pkg::OPR_DAYS, 6'd31, 4'd12, 12'd1999, 16'd1);
    offer(gda_pkg::OPR_DAYS, 6'd1, 4'd1, 12'd2000, 16'd65535);
    offer(gda_pkg::OPR_MONTHS, 6'd31, 4'd1, 12'd2000, 16'd1);
    offer(gda_pkg::OPR_MONTHS, 6'd31, 4'd1, 12'd2001, 16'd13);
    offer(gda_pkg::OPR_MONTHS, 6'd31, 4'd12, 12'd2000, 16'd65535);
    offer(gda_pkg::OPR_YEARS, 6'd29, 4'd2, 12'd2000, 16'd1);
    offer(gda_pkg::OPR_YEARS, 6'd29, 4'd2, 12'd2000, 16'd4);
    offer(gda_pkg::OPR_YEARS, 6'd1, 4'd3, 12'd2000, 16'd100);
    offer(gda_pkg::OPR_YEARS, 6'd31, 4'd12, 12'd2100, 16'd65535);
    settle();

    // Widest window: the first and last representable years.
    set_window(12'd0, 12'd4095);
    offer(gda_pkg::OPR_VALIDATE, 6'd29, 4'd2, 12'd0, 16'd0);
    offer(gda_pkg::OPR_DAYS, 6'd31, 4'd12, 12'd4095, 16'd1);
    offer(gda_pkg::OPR_YEARS, 6'd28, 4'd2, 12'd4095, 16'd0);
    offer(gda_pkg::OPR_MONTHS, 6'd30, 4'd11, 12'd4095, 16'd1);
    random_phase(PhaseItems);
    settle();

    // Back to the usual window, with one long receiver hold-off.
    set_window(gda_pkg::MinYearReset, gda_pkg::MaxYearReset);
    squeeze_req = 1'b1;
    random_phase(PhaseItems);
    settle();

    // A random, well-ordered window.
    lo = 12'($urandom_range(0, 3000));
    set_window(lo, lo + 12'($urandom_range(0, 1095)));
    random_phase(PhaseItems);
    settle();

    // A window of a single year.
    set_window(12'd2024, 12'd2024);
    random_phase(PhaseItems);
    settle();

    // An empty window rejects every year.
    set_window(12'd3000, 12'd100);
    random_phase(20);
    settle();

    set_window(12'd4095, 12'd4095);
    random_phase(20);
    settle();

    set_window(12'd1583, 12'd4095);
    random_phase(25);

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gda_pkg.sv
rtl/core/gda_sequencer.sv
rtl/core/gregorian_date_adder.sv
sim/date_result_checker.sv
sim/testbench.sv
